>>> sv/multi_class_priority_deque_assert.svh
// assertion macros for the multi-class priority deque checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef MULTI_CLASS_PRIORITY_DEQUE_ASSERT_SVH
`define MULTI_CLASS_PRIORITY_DEQUE_ASSERT_SVH

// same-cycle implication
`define MCPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcpd: implication check failed");

// next-cycle implication
`define MCPD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcpd: next-cycle check failed");

`endif

>>> sv/mcpd_pkg.sv
// shared types, constants and helpers for the multi-class priority deque
// no dependencies
`timescale 1ns / 1ps

package mcpd_pkg;

    localparam int NUM_CLASSES = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_WIDTH   = 16;

    localparam int SLOT_COUNT = NUM_CLASSES * QUEUE_DEPTH;
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int HEAD_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CLS_IN_W   = 5;
    localparam int OCC_W      = 4;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    typedef enum logic [1:0] {
        OUT_ADDED = 2'd0,
        OUT_FULL  = 2'd1,
        OUT_TAKEN = 2'd2,
        OUT_EMPTY = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [HEAD_W-1:0] head;
    } cls_ent_t;

    typedef struct packed {
        logic [TAG_WIDTH-1:0] tag;
        logic                 urgent;
    } entry_t;

    // ring position wrap, input known to stay below twice the depth
    function automatic logic [HEAD_W-1:0] wrap_pos(logic [CNT_W:0] x);
        logic [CNT_W:0] r;
        r = (x >= (CNT_W+1)'(QUEUE_DEPTH)) ? x - (CNT_W+1)'(QUEUE_DEPTH) : x;
        return HEAD_W'(r);
    endfunction

    // narrow class index folded onto the class range
    function automatic logic [CLS_W-1:0] fold_class(logic [CLS_IN_W-1:0] i);
        return CLS_W'(32'(i) % NUM_CLASSES);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(logic [CLS_W-1:0] c,
                                                 logic [HEAD_W-1:0] p);
        return SLOT_W'(int'(c) * QUEUE_DEPTH + int'(p));
    endfunction

endpackage

>>> sv/multi_class_priority_deque.sv
// multi-class priority deque: an add or an empty take goes through the class state read
// (ST_META) to the result register; a take that returns an entry adds the entry memory read
// (ST_READ); one word in flight, so a new word is taken only once the last one's result is
// registered, and a stalled result register holds the word; reset clears the per-class valid
// bits at once: all queues empty, no clearing pass, in_ready high as reset is released
`timescale 1ns / 1ps

module multi_class_priority_deque (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [mcpd_pkg::CLS_IN_W-1:0]        class_index,
    input  logic [mcpd_pkg::TAG_WIDTH-1:0]       entry_tag,
    input  logic                                 urgent_flag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mcpd_pkg::outcome_t                   outcome,
    output logic [mcpd_pkg::TAG_WIDTH-1:0]       taken_tag,
    output logic                                 taken_urgent,
    output logic [mcpd_pkg::OCC_W-1:0]           occupancy
);
    import mcpd_pkg::*;

    state_t state_reg, state_next;

    logic                 kind_reg;
    logic [CLS_W-1:0]     cls_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic                 urgent_reg;

    // class state memory with reset valid bits
    cls_ent_t             cls_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] cls_vld_reg;
    cls_ent_t             cls_rd_reg;
    logic                 cls_rd_vld_reg;
    logic                 cls_we;
    cls_ent_t             cls_wdata;

    // entry memory
    entry_t               ent_mem [SLOT_COUNT];
    entry_t               ent_rd_reg;
    logic                 ent_we;
    logic                 ent_re;
    logic [SLOT_W-1:0]    ent_waddr;
    logic [SLOT_W-1:0]    ent_raddr;

    logic                 out_valid_reg;
    outcome_t             outcome_reg;
    logic [TAG_WIDTH-1:0] taken_tag_reg;
    logic                 taken_urgent_reg;
    logic [OCC_W-1:0]     occupancy_reg;

    logic                 accept;
    logic                 out_free;
    logic                 fin;
    outcome_t             res_outcome;
    logic [TAG_WIDTH-1:0] res_tag;
    logic                 res_urgent;
    logic [CNT_W-1:0]     res_cnt;

    logic [CNT_W-1:0]     cur_cnt;
    logic [HEAD_W-1:0]    cur_head;
    logic                 q_full;
    logic                 q_empty;
    logic [HEAD_W-1:0]    head_dec;
    logic [HEAD_W-1:0]    head_inc;
    logic [HEAD_W-1:0]    tail_pos;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign cur_cnt  = cls_rd_vld_reg ? cls_rd_reg.cnt  : '0;
    assign cur_head = cls_rd_vld_reg ? cls_rd_reg.head : '0;
    assign q_full   = (cur_cnt >= CNT_W'(QUEUE_DEPTH));
    assign q_empty  = (cur_cnt == '0);
    assign head_dec = wrap_pos((CNT_W+1)'(cur_head) + (CNT_W+1)'(QUEUE_DEPTH - 1));
    assign head_inc = wrap_pos((CNT_W+1)'(cur_head) + (CNT_W+1)'(1));
    assign tail_pos = wrap_pos((CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_cnt));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                if (kind_reg == KIND_TAKE && !q_empty)
                begin
                    state_next = ST_READ;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls and result
    always_comb
    begin
        fin         = 1'b0;
        cls_we      = 1'b0;
        cls_wdata   = '0;
        ent_we      = 1'b0;
        ent_re      = 1'b0;
        ent_waddr   = slot_of(cls_reg, urgent_reg ? head_dec : tail_pos);
        ent_raddr   = slot_of(cls_reg, cur_head);
        res_outcome = OUT_ADDED;
        res_tag     = '0;
        res_urgent  = 1'b0;
        res_cnt     = cur_cnt;
        case (state_reg)
            ST_META:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    fin = out_free;
                    if (q_full)
                    begin
                        res_outcome = OUT_FULL;
                    end
                    else
                    begin
                        res_outcome    = OUT_ADDED;
                        res_cnt        = cur_cnt + CNT_W'(1);
                        cls_we         = out_free;
                        ent_we         = out_free;
                        cls_wdata.cnt  = cur_cnt + CNT_W'(1);
                        cls_wdata.head = urgent_reg ? head_dec : cur_head;
                    end
                end
                else if (q_empty)
                begin
                    fin         = out_free;
                    res_outcome = OUT_EMPTY;
                end
                else
                begin
                    ent_re = 1'b1;
                end
            end
            ST_READ:
            begin
                fin            = out_free;
                res_outcome    = OUT_TAKEN;
                res_tag        = ent_rd_reg.tag;
                res_urgent     = ent_rd_reg.urgent;
                res_cnt        = cur_cnt - CNT_W'(1);
                cls_we         = out_free;
                cls_wdata.cnt  = cur_cnt - CNT_W'(1);
                cls_wdata.head = head_inc;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            cls_vld_reg    <= '0;
            cls_rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cls_we)
            begin
                cls_vld_reg[cls_reg] <= 1'b1;
            end
            if (accept)
            begin
                cls_rd_vld_reg <= cls_vld_reg[fold_class(class_index)];
            end
        end
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            cls_reg    <= fold_class(class_index);
            tag_reg    <= entry_tag;
            urgent_reg <= urgent_flag;
        end
        if (fin)
        begin
            outcome_reg      <= res_outcome;
            taken_tag_reg    <= res_tag;
            taken_urgent_reg <= res_urgent;
            occupancy_reg    <= OCC_W'(res_cnt);
        end
    end

    // class state memory
    always_ff @(posedge clk)
    begin
        if (cls_we)
        begin
            cls_mem[cls_reg] <= cls_wdata;
        end
        if (accept)
        begin
            cls_rd_reg <= cls_mem[fold_class(class_index)];
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= '{tag: tag_reg, urgent: urgent_reg};
        end
        if (ent_re)
        begin
            ent_rd_reg <= ent_mem[ent_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = outcome_reg;
    assign taken_tag    = taken_tag_reg;
    assign taken_urgent = taken_urgent_reg;
    assign occupancy    = occupancy_reg;

endmodule

>>> sv/mcpd_checker.sv
// port-level checks for the multi-class priority deque, bound to the top level
// depends on mcpd_pkg and multi_class_priority_deque_assert.svh
`timescale 1ns / 1ps
`include "multi_class_priority_deque_assert.svh"

module mcpd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           kind,
    input logic [mcpd_pkg::CLS_IN_W-1:0]  class_index,
    input logic [mcpd_pkg::TAG_WIDTH-1:0] entry_tag,
    input logic                           urgent_flag,
    input logic                           out_valid,
    input logic                           out_ready,
    input mcpd_pkg::outcome_t             outcome,
    input logic [mcpd_pkg::TAG_WIDTH-1:0] taken_tag,
    input logic                           taken_urgent,
    input logic [mcpd_pkg::OCC_W-1:0]     occupancy
);
    import mcpd_pkg::*;

    // a stalled result word holds
    `MCPD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(taken_tag) && $stable(occupancy))

    // one word in flight
    `MCPD_ASSERT_NXT(a_one_inflight, in_valid && in_ready, !in_ready)

    `MCPD_ASSERT_IMP(a_empty_word, out_valid && outcome == OUT_EMPTY, occupancy == '0 && taken_tag == '0 && !taken_urgent)

    `MCPD_ASSERT_IMP(a_full_word, out_valid && outcome == OUT_FULL, occupancy == OCC_W'(QUEUE_DEPTH) && taken_tag == '0 && !taken_urgent)

    `MCPD_ASSERT_IMP(a_added_word, out_valid && outcome == OUT_ADDED, occupancy != '0 && taken_tag == '0 && !taken_urgent)

endmodule

bind multi_class_priority_deque mcpd_checker u_mcpd_checker (.*);

>>> tb/multi_class_priority_deque_tb.sv
// self-checking testbench for the multi-class priority deque: directed and random
// add/take words, a per-class ring predictor, and result checks; uses mcpd_pkg
`timescale 1ns / 1ps

module multi_class_priority_deque_tb;

    import mcpd_pkg::*;

    localparam int WORD_TARGET    = 1950;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_CYCLE  = 3000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct {
        logic                 kind;
        logic [CLS_IN_W-1:0]  cls;
        logic [TAG_WIDTH-1:0] tag;
        logic                 urgent;
    } deque_word_t;

    typedef struct {
        outcome_t             outcome;
        logic [TAG_WIDTH-1:0] tag;
        logic                 urgent;
        logic [OCC_W-1:0]     occ;
    } deque_result_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_SPARSE
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 kind = KIND_ADD;
    logic [CLS_IN_W-1:0]  class_index = '0;
    logic [TAG_WIDTH-1:0] entry_tag = '0;
    logic                 urgent_flag = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    outcome_t             outcome;
    logic [TAG_WIDTH-1:0] taken_tag;
    logic                 taken_urgent;
    logic [OCC_W-1:0]     occupancy;

    deque_word_t   queued_words[$];
    deque_result_t expected_outcomes[$];

    logic [TAG_WIDTH-1:0] slot_tags [SLOT_COUNT];
    logic                 slot_urgent [SLOT_COUNT];
    int unsigned          class_fill [NUM_CLASSES];
    int unsigned          class_front [NUM_CLASSES];

    int          outcome_tally [4];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          stalled_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          rx_cycle = 0;
    logic        long_hold_done = 1'b0;
    rx_mode_t    rx_mode = RX_OPEN;
    deque_word_t next_word;
    deque_word_t accepted_word;
    deque_result_t due;

    multi_class_priority_deque uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .class_index  (class_index),
        .entry_tag    (entry_tag),
        .urgent_flag  (urgent_flag),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .outcome      (outcome),
        .taken_tag    (taken_tag),
        .taken_urgent (taken_urgent),
        .occupancy    (occupancy)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic queue_word(input logic k, input int c, input int t, input logic u);
        deque_word_t w;
        w.kind   = k;
        w.cls    = CLS_IN_W'(c);
        w.tag    = TAG_WIDTH'(t);
        w.urgent = u;
        queued_words.push_back(w);
    endtask

    // ring per class: urgent words step the head back, regular words land at head + fill
    task automatic advance_deques(input deque_word_t w);
        deque_result_t r;
        int            c;
        int unsigned   n;
        int unsigned   h;
        int            s;
        c = int'(w.cls) % NUM_CLASSES;
        n = class_fill[c];
        h = class_front[c];
        r.outcome = OUT_ADDED;
        r.tag     = '0;
        r.urgent  = 1'b0;
        if (w.kind == KIND_ADD)
        begin
            if (n >= QUEUE_DEPTH)
            begin
                r.outcome = OUT_FULL;
            end
            else
            begin
                if (w.urgent)
                begin
                    h = (h + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    class_front[c] = h;
                    s = c * QUEUE_DEPTH + int'(h);
                end
                else
                begin
                    s = c * QUEUE_DEPTH + int'((h + n) % QUEUE_DEPTH);
                end
                slot_tags[s]   = w.tag;
                slot_urgent[s] = w.urgent;
                n++;
                class_fill[c] = n;
            end
        end
        else if (n == 0)
        begin
            r.outcome = OUT_EMPTY;
        end
        else
        begin
            s = c * QUEUE_DEPTH + int'(h);
            r.outcome = OUT_TAKEN;
            r.tag     = slot_tags[s];
            r.urgent  = slot_urgent[s];
            class_front[c] = (h + 1) % QUEUE_DEPTH;
            n--;
            class_fill[c] = n;
        end
        r.occ = OCC_W'(n);
        outcome_tally[int'(r.outcome)]++;
        expected_outcomes.push_back(r);
    endtask

    // driver: bursts of words separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                accepted_word.kind   = kind;
                accepted_word.cls    = class_index;
                accepted_word.tag    = entry_tag;
                accepted_word.urgent = urgent_flag;
                advance_deques(accepted_word);
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0 || queued_words.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_word = queued_words.pop_front();
                    in_valid    <= 1'b1;
                    kind        <= next_word.kind;
                    class_index <= next_word.cls;
                    entry_tag   <= next_word.tag;
                    urgent_flag <= next_word.urgent;
                    burst_left--;
                end
            end
        end
    end

    // receiver: stall pattern redrawn among the four rx_mode_t modes, plus one long hold
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && rx_cycle >= HOLD_AT_CYCLE)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (rx_cycle % 64 == 0)
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                case (rx_mode)
                    RX_OPEN:         out_ready <= 1'b1;
                    RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: out_ready <= (rx_cycle % 4 == 0);
                    default:         out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing expected, outcome %s",
                                          outcome.name()));
            end
            else
            begin
                due = expected_outcomes.pop_front();
                if (outcome !== due.outcome)
                    report_mismatch($sformatf("outcome %0d, expected %0d",
                                              outcome, due.outcome));
                if (taken_tag !== due.tag)
                    report_mismatch($sformatf("taken_tag %h, expected %h",
                                              taken_tag, due.tag));
                if (taken_urgent !== due.urgent)
                    report_mismatch($sformatf("taken_urgent %b, expected %b",
                                              taken_urgent, due.urgent));
                if (occupancy !== due.occ)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              occupancy, due.occ));
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
    end

    initial
    begin
        int add_pct;
        int focus;
        int seg;
        int c;
        logic k;

        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            class_fill[i]  = 0;
            class_front[i] = 0;
        end
        for (int i = 0; i < 4; i++)
            outcome_tally[i] = 0;

        // take from empty, extreme tags and classes
        queue_word(KIND_TAKE, 0, 16'hFFFF, 1'b1);
        queue_word(KIND_ADD, 31, 16'hFFFF, 1'b0);
        queue_word(KIND_ADD, 31, 16'h0000, 1'b1);
        queue_word(KIND_TAKE, 31, 16'h1234, 1'b0);
        queue_word(KIND_TAKE, 31, 16'h0000, 1'b1);
        queue_word(KIND_TAKE, 31, 16'hFFFF, 1'b0);
        // fill one class with mixed urgency, reject when full, then drain past empty
        for (int i = 0; i < QUEUE_DEPTH; i++)
            queue_word(KIND_ADD, 5, 16'hA500 + i, 1'(i % 2));
        queue_word(KIND_ADD, 5, 16'hDEAD, 1'b1);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            queue_word(KIND_TAKE, 5, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));

        while (queued_words.size() < WORD_TARGET)
        begin
            add_pct = $urandom_range(15, 85);
            focus   = $urandom_range(0, NUM_CLASSES - 1);
            seg     = $urandom_range(20, 80);
            repeat (seg)
            begin
                if ($urandom_range(0, 9) < 8)
                    c = (focus + $urandom_range(0, 2)) % NUM_CLASSES;
                else
                    c = $urandom_range(0, 31);
                k = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_TAKE;
                queue_word(k, c, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while ((queued_words.size() > 0 || in_valid || expected_outcomes.size() > 0)
               && stalled_cycles < WATCHDOG_LIMIT)
            @(negedge clk);

        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d words still queued, %0d results outstanding",
                     queued_words.size(), expected_outcomes.size());
            $display("multi_class_priority_deque_tb NOT OK");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(negedge clk);
            $display("%0d words checked: %0d added, %0d rejected full, %0d taken, %0d empty",
                     results_seen, outcome_tally[int'(OUT_ADDED)],
                     outcome_tally[int'(OUT_FULL)], outcome_tally[int'(OUT_TAKEN)],
                     outcome_tally[int'(OUT_EMPTY)]);
            $display("receiver held off once for %0d cycles, %0d mismatches",
                     LONG_HOLD, mismatch_count);
            if (mismatch_count == 0 && expected_outcomes.size() == 0)
                $display("multi_class_priority_deque_tb OK");
            else
                $display("multi_class_priority_deque_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/mcpd_pkg.sv
sv/multi_class_priority_deque.sv
sv/mcpd_checker.sv
tb/multi_class_priority_deque_tb.sv
